// ===== hw/rtl/bmprle_pkg.sv =====
// shared types and constants for the bmp rle8/rle4 palette decoder
// no dependencies
`timescale 1ns / 1ps

package bmprle_pkg;

	// palette geometry
	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);
	localparam int COLOR_W   = 15;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// record kinds
	localparam logic [1:0] KIND_RUN = 2'd0;
	localparam logic [1:0] KIND_EOL = 2'd1;
	localparam logic [1:0] KIND_EOB = 2'd2;
	localparam logic [1:0] KIND_ERR = 2'd3;

	// input actions
	localparam logic ACT_PALETTE = 1'b0;
	localparam logic ACT_STREAM  = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic [7:0] palette_index;
		logic [7:0] palette_red;
		logic [7:0] palette_green;
		logic [7:0] palette_blue;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         record_kind;
		logic [COLOR_W-1:0] first_color;
		logic [COLOR_W-1:0] second_color;
		logic [7:0]         run_length;
	} rec_t;

	// one unit of work for the back part: a palette write or a record lookup
	typedef struct packed {
		logic               is_read;
		logic [1:0]         kind;
		logic [7:0]         run_len;
		logic [PAL_AW-1:0]  idx0;
		logic [PAL_AW-1:0]  idx1;
		logic               ok0;
		logic               ok1;
		logic [COLOR_W-1:0] wdata;
	} op_t;

endpackage

// ===== hw/rtl/bmprle_ram.sv =====
// generic single write port ram with registered read and read enable
// no dependencies
`timescale 1ns / 1ps

module bmprle_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/bmprle_front.sv =====
// front part: accepts items, runs the rle phase machine, emits work ops
// depends on bmprle_pkg
`timescale 1ns / 1ps

module bmprle_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  bmprle_pkg::cmd_t   cmd,
	input  logic               nibble_mode,
	output logic               push,
	output bmprle_pkg::op_t    op
);

	import bmprle_pkg::*;

	localparam logic [2:0] PH_COUNT  = 3'd0;
	localparam logic [2:0] PH_VALUE  = 3'd1;
	localparam logic [2:0] PH_ESCAPE = 3'd2;
	localparam logic [2:0] PH_ABS    = 3'd3;
	localparam logic [2:0] PH_PAD    = 3'd4;

	logic [2:0] phase_q, phase_d;
	logic [7:0] pending_q, pending_d;
	logic [7:0] abs_left_q, abs_left_d;
	logic       pad_q, pad_d;
	logic       err_q, err_d;

	logic [7:0] b;
	logic [7:0] idx_hi, idx_lo;
	logic [7:0] step_n;
	logic [7:0] left_next;

	assign b      = cmd.data_byte;
	assign idx_hi = nibble_mode ? {4'd0, b[7:4]} : b;
	assign idx_lo = nibble_mode ? (b & 8'h0f) : b;

	// pixels consumed by one absolute data byte
	always_comb begin
		if (nibble_mode) begin
			step_n = (abs_left_q >= 8'd2) ? 8'd2 : abs_left_q;
		end else begin
			step_n = (abs_left_q >= 8'd1) ? 8'd1 : 8'd0;
		end
	end
	assign left_next = abs_left_q - step_n;

	always_comb begin
		phase_d    = phase_q;
		pending_d  = pending_q;
		abs_left_d = abs_left_q;
		pad_d      = pad_q;
		err_d      = err_q;
		push       = 1'b0;
		op         = '0;

		if (accept && cmd.action == ACT_PALETTE) begin
			push     = 1'b1;
			op.is_read = 1'b0;
			op.idx0  = cmd.palette_index[PAL_AW-1:0];
			op.ok0   = (int'(cmd.palette_index) < PAL_DEPTH);
			op.wdata = {cmd.palette_red[7:3], cmd.palette_green[7:3], cmd.palette_blue[7:3]};
		end else if (accept && !err_q) begin
			op.is_read = 1'b1;
			op.idx0    = idx_hi[PAL_AW-1:0];
			op.idx1    = idx_lo[PAL_AW-1:0];
			op.ok0     = (int'(idx_hi) < PAL_DEPTH);
			op.ok1     = (int'(idx_lo) < PAL_DEPTH);
			case (phase_q)
				PH_VALUE: begin
					push       = 1'b1;
					op.kind    = KIND_RUN;
					op.run_len = pending_q;
					phase_d    = PH_COUNT;
				end
				PH_ESCAPE: begin
					phase_d = PH_COUNT;
					case (b)
						8'd0: begin
							push    = 1'b1;
							op.kind = KIND_EOL;
						end
						8'd1: begin
							push    = 1'b1;
							op.kind = KIND_EOB;
						end
						8'd2: begin
							// delta is not supported: flag it and go quiet
							push    = 1'b1;
							op.kind = KIND_ERR;
							err_d   = 1'b1;
						end
						default: begin
							abs_left_d = b;
							pad_d      = 1'b0;
							phase_d    = PH_ABS;
						end
					endcase
				end
				PH_ABS: begin
					push       = 1'b1;
					op.kind    = KIND_RUN;
					op.run_len = step_n;
					abs_left_d = left_next;
					pad_d      = ~pad_q;
					if (left_next == 8'd0) begin
						phase_d = (~pad_q) ? PH_PAD : PH_COUNT;
					end
				end
				PH_PAD: begin
					pad_d   = 1'b0;
					phase_d = PH_COUNT;
				end
				default: begin
					if (b == 8'd0) begin
						phase_d = PH_ESCAPE;
					end else begin
						pending_d = b;
						phase_d   = PH_VALUE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COUNT;
			pending_q  <= '0;
			abs_left_q <= '0;
			pad_q      <= 1'b0;
			err_q      <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			pending_q  <= pending_d;
			abs_left_q <= abs_left_d;
			pad_q      <= pad_d;
			err_q      <= err_d;
		end
	end

endmodule

// ===== hw/rtl/bmprle_queue.sv =====
// small register fifo of work ops between front and back
// depends on bmprle_pkg
`timescale 1ns / 1ps

module bmprle_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bmprle_pkg::op_t   push_op,
	input  logic              pop,
	output logic              head_valid,
	output bmprle_pkg::op_t   head_op,
	output logic              full
);

	import bmprle_pkg::*;

	op_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign head_valid = (count_q != '0);
	assign head_op    = slot_q[rd_ptr_q];
	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/bmprle_back.sv =====
// back part: owns the palette, applies writes and looks up record colors in order
// depends on bmprle_pkg and bmprle_ram
`timescale 1ns / 1ps

module bmprle_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  bmprle_pkg::op_t   head_op,
	output logic              pop,
	output logic              rec_valid,
	input  logic              rec_stall,
	output bmprle_pkg::rec_t  rec
);

	import bmprle_pkg::*;

	logic               rd, wr;
	logic [COLOR_W-1:0] rdata0, rdata1;

	logic               valid_s1;
	logic [1:0]         kind_s1;
	logic [7:0]         len_s1;
	logic               ok0_s1, ok1_s1;

	assign pop = head_valid && (!valid_s1 || !rec_stall);
	assign rd  = pop && head_op.is_read;
	assign wr  = pop && !head_op.is_read && head_op.ok0;

	// two copies of the palette so both nibble colors are read in the same cycle
	bmprle_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_pal0 (
		.clk   (clk),
		.we    (wr),
		.waddr (head_op.idx0),
		.wdata (head_op.wdata),
		.re    (rd),
		.raddr (head_op.idx0),
		.rdata (rdata0)
	);

	bmprle_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_pal1 (
		.clk   (clk),
		.we    (wr),
		.waddr (head_op.idx0),
		.wdata (head_op.wdata),
		.re    (rd),
		.raddr (head_op.idx1),
		.rdata (rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= head_op.is_read;
		end else if (!rec_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			kind_s1 <= head_op.kind;
			len_s1  <= head_op.run_len;
			ok0_s1  <= head_op.ok0;
			ok1_s1  <= head_op.ok1;
		end
	end

	// markers carry no color; indexes past the palette read as black
	assign rec_valid          = valid_s1;
	assign rec.record_kind    = kind_s1;
	assign rec.run_length     = len_s1;
	assign rec.first_color    = (kind_s1 == KIND_RUN && ok0_s1) ? rdata0 : '0;
	assign rec.second_color   = (kind_s1 == KIND_RUN && ok1_s1) ? rdata1 : '0;

endmodule

// ===== hw/rtl/bmp_rle_palette_decoder_unit.sv =====
// top level of the bmp rle8/rle4 palette decoder
// depends on bmprle_pkg, bmprle_front, bmprle_queue, bmprle_back, bmprle_ram
`timescale 1ns / 1ps

// usage
// - cmd channel (cmd_valid / cmd_stall / cmd): one item per accepted edge, either a
//   palette write (rgb888 folded to rgb555) or one compressed stream byte
// - rec channel (rec_valid / rec_stall / rec): pixel runs, end of line, end of bitmap
//   and the delta error record, at most one record per stream byte
// - mode channel (mode_valid / mode_ready / mode_data): nibble_mode, 0 rle8, 1 rle4;
//   always ready, write it only while the block is idle
// timing
// - one item per cycle sustained while rec_stall is low; the front phase machine takes
//   every item as it is accepted and the back does one palette access per cycle
// - path: the item is written into the op queue, its palette read is issued when it
//   reaches the head, and the record shows on rec from the registered read data
// - palette writes travel through the same queue, so lookups always see the palette
//   as it stood when their byte was accepted
// stall and reset
// - rec_stall holds the record in place; the queue keeps filling and cmd_stall rises
//   only when it is full
// - reset clears the phase machine, the error flag, the queue and the output valid;
//   the palette itself is not cleared and must be written before use
// - after a delta escape, stream bytes are dropped until reset

module bmp_rle_palette_decoder_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  bmprle_pkg::cmd_t  cmd,
	output logic              rec_valid,
	input  logic              rec_stall,
	output bmprle_pkg::rec_t  rec,
	input  logic              mode_valid,
	output logic              mode_ready,
	input  logic              mode_data
);

	import bmprle_pkg::*;

	logic nibble_mode_q;
	logic accept;
	logic push, pop, full, head_valid;
	op_t  push_op, head_op;

	// configuration register
	assign mode_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_mode_q <= 1'b0;
		end else if (mode_valid && mode_ready) begin
			nibble_mode_q <= mode_data;
		end
	end

	// input side stalls only on a full queue
	assign cmd_stall = full;
	assign accept    = cmd_valid && !cmd_stall;

	bmprle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.nibble_mode (nibble_mode_q),
		.push        (push),
		.op          (push_op)
	);

	bmprle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op),
		.full       (full)
	);

	bmprle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec        (rec)
	);

endmodule
